FILE: hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and defaults for the point-in-polygon tester
// Sequencer states, multiplier step codes and default sizes.
// ----------------------------------------------------------------------------
package pip_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF = 128;
    localparam int COORD_WIDTH_DEF  = 16;

    // request codes on req_type
    localparam logic REQ_VERTEX = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREV,
        S_LOAD,
        S_MUL,
        S_EVAL
    } pip_state_t;

    // products taken by the shared multiplier, in order, for one edge
    typedef enum logic [1:0] {
        MS_AJX_AIY,
        MS_AIX_AJY,
        MS_AJX_AIX,
        MS_AJY_AIY
    } mul_step_t;

endpackage

FILE: hdl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: ray casting point-in-polygon tester
// Stores polygon vertices in a small memory and answers inside/boundary
// queries by walking the polygon's edges with one shared multiplier.
// ----------------------------------------------------------------------------
//
//  channel   signals                                      handshake
//  -------   -------------------------------------------  -------------------
//  request   req_type, first_vertex, coord_x, coord_y      start & !busy
//  result    inside_res                                   done, one cycle
//
//  A vertex item is stored in the cycle it is accepted; busy stays low.
//  A query fetches the closing vertex first, then for each edge does one
//  memory read and four passes through the shared multiplier plus an
//  evaluation; a boundary hit ends the walk early. An empty polygon answers
//  without a walk. Reset clears the vertex count and the sequencer; the
//  vertex memory is not cleared. The result is shown for one cycle and
//  cannot be held off.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          req_type,
    input  logic                          first_vertex,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    output logic                          done,
    output logic                          inside_res
);
    import pip_pkg::*;

    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int DW     = COORD_WIDTH + 1;   // coordinate difference
    localparam int PW     = 2 * DW;            // product
    localparam int AW     = PW + 1;            // sum of two products

    // vertex memory
    logic [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
    logic [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
    logic [COORD_WIDTH-1:0] rd_x_reg, rd_y_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   wr_en;

    // control state
    pip_state_t             state_reg, state_next;
    mul_step_t              step_reg, step_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   par_reg, par_next;
    logic                   done_reg, done_next;

    // payload state
    logic                   inside_reg, inside_next;
    logic signed [COORD_WIDTH-1:0] px_reg, px_next;
    logic signed [COORD_WIDTH-1:0] py_reg, py_next;
    logic signed [DW-1:0]   ajx_reg, ajx_next;
    logic signed [DW-1:0]   ajy_reg, ajy_next;
    logic signed [DW-1:0]   aix_reg, aix_next;
    logic signed [DW-1:0]   aiy_reg, aiy_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   cr_reg, cr_next;
    logic signed [AW-1:0]   dt_reg, dt_next;

    // datapath helpers
    logic                   accept;
    logic [CNT_W-1:0]       wr_idx;
    logic signed [DW-1:0]   dx, dy;
    logic signed [DW-1:0]   mul_a, mul_b;
    logic signed [AW-1:0]   prod_ext;
    logic signed [AW-1:0]   dt_sum;
    logic                   hit, straddle, beyond;

    assign accept   = start && !busy;
    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign inside_res = inside_reg;

    // vertex write index: a first vertex restarts the store
    assign wr_idx  = first_vertex ? '0 : count_reg;
    assign wr_en   = accept && (req_type == REQ_VERTEX) && (wr_idx < CNT_W'(MAX_VERTICES));
    assign wr_addr = wr_idx[ADDR_W-1:0];

    // read address: closing vertex at query accept, then the edge index
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_addr = ADDR_W'(count_reg - CNT_W'(1));
        end
        else
        begin
            rd_addr = idx_reg[ADDR_W-1:0];
        end
    end

    // vertex memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= coord_x;
            mem_y[wr_addr] <= coord_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    // read vertex relative to the query point
    assign dx = DW'($signed(rd_x_reg)) - DW'(px_reg);
    assign dy = DW'($signed(rd_y_reg)) - DW'(py_reg);

    // shared multiplier operand select
    always_comb
    begin
        unique case (step_reg)
            MS_AJX_AIY: begin mul_a = ajx_reg; mul_b = aiy_reg; end
            MS_AIX_AJY: begin mul_a = aix_reg; mul_b = ajy_reg; end
            MS_AJX_AIX: begin mul_a = ajx_reg; mul_b = aix_reg; end
            MS_AJY_AIY: begin mul_a = ajy_reg; mul_b = aiy_reg; end
            default:    begin mul_a = ajx_reg; mul_b = aiy_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod_ext = AW'(prod_reg);
    assign dt_sum   = dt_reg + prod_ext;

    // edge tests: cross product is cr_reg, dot product is dt_sum
    assign hit      = (cr_reg == '0) && (dt_sum <= 0);
    assign straddle = !(((aiy_reg > 0) && (ajy_reg > 0)) || ((aiy_reg < 0) && (ajy_reg < 0)));
    assign beyond   = (cr_reg == '0) || ((cr_reg > 0) == (ajy_reg > aiy_reg));

    // next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        par_next    = par_reg;
        done_next   = 1'b0;
        inside_next = inside_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        ajx_next    = ajx_reg;
        ajy_next    = ajy_reg;
        aix_next    = aix_reg;
        aiy_next    = aiy_reg;
        cr_next     = cr_reg;
        dt_next     = dt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_VERTEX)
                    begin
                        if (wr_en)
                        begin
                            count_next = wr_idx + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        inside_next = 1'b0;
                    end
                    else
                    begin
                        px_next    = coord_x;
                        py_next    = coord_y;
                        idx_next   = '0;
                        par_next   = 1'b0;
                        state_next = S_PREV;
                    end
                end
            end
            // closing vertex becomes the first edge's start
            S_PREV:
            begin
                ajx_next   = dx;
                ajy_next   = dy;
                state_next = S_LOAD;
            end
            // current vertex arrives, the read index moves to the next vertex
            S_LOAD:
            begin
                aix_next   = dx;
                aiy_next   = dy;
                idx_next   = idx_reg + CNT_W'(1);
                step_next  = MS_AJX_AIY;
                state_next = S_MUL;
            end
            // four products through the shared multiplier
            S_MUL:
            begin
                unique case (step_reg)
                    MS_AJX_AIY:
                    begin
                        step_next = MS_AIX_AJY;
                    end
                    MS_AIX_AJY:
                    begin
                        cr_next   = prod_ext;
                        step_next = MS_AJX_AIX;
                    end
                    MS_AJX_AIX:
                    begin
                        cr_next   = cr_reg - prod_ext;
                        step_next = MS_AJY_AIY;
                    end
                    MS_AJY_AIY:
                    begin
                        dt_next    = prod_ext;
                        state_next = S_EVAL;
                    end
                    default:
                    begin
                        step_next = MS_AJX_AIY;
                    end
                endcase
            end
            // decide this edge, move on or finish
            S_EVAL:
            begin
                ajx_next = aix_reg;
                ajy_next = aiy_reg;
                if (hit)
                begin
                    done_next   = 1'b1;
                    inside_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    priority if (ajy_reg == aiy_reg)
                    begin
                        par_next = par_reg;
                    end
                    else if ((ajy_reg == '0) && (ajx_reg <= 0))
                    begin
                        par_next = par_reg ^ (ajy_reg < aiy_reg);
                    end
                    else if ((aiy_reg == '0) && (aix_reg <= 0))
                    begin
                        par_next = par_reg ^ (aiy_reg < ajy_reg);
                    end
                    else
                    begin
                        par_next = par_reg ^ (straddle && beyond);
                    end

                    if (idx_reg == count_reg)
                    begin
                        done_next   = 1'b1;
                        inside_next = par_next;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= MS_AJX_AIY;
            count_reg <= '0;
            idx_reg   <= '0;
            par_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            par_reg   <= par_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        inside_reg <= inside_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ajx_reg    <= ajx_next;
        ajy_reg    <= ajy_next;
        aix_reg    <= aix_next;
        aiy_reg    <= aiy_next;
        cr_reg     <= cr_next;
        dt_reg     <= dt_next;
    end

endmodule
